/* hw/rtl/qpm_pkg.sv */
package qpm_pkg;

	localparam int IN_W       = 32;
	localparam int SYM_W      = 4;
	localparam int NUM_SLOTS  = IN_W / SYM_W;
	localparam int Q_W        = 5;
	localparam int N_W        = 4;
	localparam int QB_W       = 3;
	localparam int POS_W      = 7;
	localparam int SUM_W      = POS_W + 1;
	localparam int OUT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int MOD_STEPS  = 3;
	localparam int MOD_W      = POS_W + MOD_STEPS - 1;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 2'd1;

	localparam logic [Q_W-1:0] ALPHABET_RST = 5'd2;
	localparam logic [N_W-1:0] LENGTH_RST   = 4'd3;

	typedef struct packed {
		logic [Q_W-1:0]   q_eff;
		logic [QB_W-1:0]  qb;
		logic [N_W-1:0]   n_eff;
		logic [POS_W-1:0] total;
	} cfg_t;

	function automatic logic [QB_W-1:0] sym_bits(input logic [Q_W-1:0] q);
		logic [QB_W-1:0] b;
		priority if (q <= 5'd2) begin
			b = 3'd1;
		end else if (q <= 5'd4) begin
			b = 3'd2;
		end else if (q <= 5'd8) begin
			b = 3'd3;
		end else if (q <= 5'd16) begin
			b = 3'd4;
		end else begin
			b = 3'd5;
		end
		return b;
	endfunction

	function automatic cfg_t derive(input logic [Q_W-1:0] q_raw, input logic [N_W-1:0] n_raw,
			input logic [Q_W-1:0] q_cap, input logic [N_W-1:0] n_cap);
		cfg_t c;
		logic [POS_W-1:0] span;
		c.q_eff = q_raw;
		if (c.q_eff < 5'd2) begin
			c.q_eff = 5'd2;
		end
		if (c.q_eff > q_cap) begin
			c.q_eff = q_cap;
		end
		c.n_eff = n_raw;
		if (c.n_eff == '0) begin
			c.n_eff = 4'd1;
		end
		if (c.n_eff > n_cap) begin
			c.n_eff = n_cap;
		end
		c.qb = sym_bits(c.q_eff);
		span = POS_W'({3'd0, c.n_eff - 4'd1}) * POS_W'({4'd0, c.qb});
		c.total = POS_W'({2'd0, c.q_eff}) + span;
		return c;
	endfunction

	// quotient of a 4-bit value by a modulus of at least 2 fits in three bits
	function automatic logic [SYM_W-1:0] sym_mod(input logic [SYM_W-1:0] v,
			input logic [POS_W-1:0] m);
		logic [MOD_W-1:0] r;
		logic [MOD_W-1:0] d;
		r = MOD_W'(v);
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			d = MOD_W'(m) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[SYM_W-1:0];
	endfunction

endpackage

/* hw/rtl/qary_to_permutation_mapper.sv */
// Channel   Handshake                Payload
// input     start, busy              symbols
// result    strobe (no back-press)   perm_symbol, position, last, symbol_error
// config    cfg_valid, cfg_ready     cfg_index, cfg_data
//
// One vector gives N = q + (n-1)*Q results, one per cycle out of the modulus pipeline.
// A vector occupies the back end for all N of its results; queued vectors follow with no gap.
// A vector passes the front register, the queue write, the issue register and one
// pipeline stage per modulus before its first result appears.
// arst_n clears control state and loads the reset register values.
// busy rises only while the front stage holds a vector and the two-entry queue is full.
module qary_to_permutation_mapper #(
	parameter int MAX_LENGTH   = 8,
	parameter int MAX_ALPHABET = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [qpm_pkg::IN_W-1:0]         symbols,
	output logic                             strobe,
	output logic [qpm_pkg::OUT_W-1:0]        perm_symbol,
	output logic [qpm_pkg::OUT_W-1:0]        position,
	output logic                             last,
	output logic                             symbol_error,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [qpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qpm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int FIFO_W = MAX_LENGTH * qpm_pkg::SYM_W + 1;
	localparam logic [qpm_pkg::Q_W-1:0] QCAP =
		qpm_pkg::Q_W'((MAX_ALPHABET > 31) ? 31 : MAX_ALPHABET);
	localparam logic [qpm_pkg::N_W-1:0] NCAP = qpm_pkg::N_W'(MAX_LENGTH);

	logic [qpm_pkg::Q_W-1:0]                   alph_q;
	logic [qpm_pkg::N_W-1:0]                   len_q;
	qpm_pkg::cfg_t                             cfg_q;
	logic                                      push;
	logic                                      push_err;
	logic [MAX_LENGTH-1:0][qpm_pkg::SYM_W-1:0] push_vr;
	logic                                      full;
	logic                                      pop;
	logic                                      rd_valid;
	logic [FIFO_W-1:0]                         rd_data;
	logic [MAX_LENGTH-1:0][qpm_pkg::SYM_W-1:0] rd_vr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alph_q <= qpm_pkg::ALPHABET_RST;
			len_q  <= qpm_pkg::LENGTH_RST;
			cfg_q  <= qpm_pkg::derive(qpm_pkg::ALPHABET_RST, qpm_pkg::LENGTH_RST, QCAP, NCAP);
		end else begin
			if (cfg_valid && cfg_ready && cfg_index == qpm_pkg::REG_ALPHABET) begin
				alph_q <= cfg_data;
			end
			if (cfg_valid && cfg_ready && cfg_index == qpm_pkg::REG_LENGTH) begin
				len_q <= cfg_data[qpm_pkg::N_W-1:0];
			end
			cfg_q <= qpm_pkg::derive(alph_q, len_q, QCAP, NCAP);
		end
	end

	qpm_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (start),
		.symbols  (symbols),
		.busy     (busy),
		.push     (push),
		.push_err (push_err),
		.push_vr  (push_vr),
		.full     (full)
	);

	qpm_fifo #(
		.WIDTH(FIFO_W),
		.DEPTH(2)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  ({push_err, push_vr}),
		.full     (full),
		.pop      (pop),
		.rd_valid (rd_valid),
		.rd_data  (rd_data)
	);

	assign rd_vr = rd_data[FIFO_W-2:0];

	qpm_back #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.rd_valid     (rd_valid),
		.rd_err       (rd_data[FIFO_W-1]),
		.rd_vr        (rd_vr),
		.pop          (pop),
		.strobe       (strobe),
		.perm_symbol  (perm_symbol),
		.position     (position),
		.last         (last),
		.symbol_error (symbol_error)
	);

endmodule

/* hw/rtl/qpm_fifo.sv */
module qpm_fifo #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/qpm_front.sv */
module qpm_front #(
	parameter int MAX_LENGTH = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  qpm_pkg::cfg_t                           cfg,
	input  logic                                    start,
	input  logic [qpm_pkg::IN_W-1:0]                symbols,
	output logic                                    busy,
	output logic                                    push,
	output logic                                    push_err,
	output logic [MAX_LENGTH-1:0][qpm_pkg::SYM_W-1:0] push_vr,
	input  logic                                    full
);

	logic                       s1_valid_q;
	logic [qpm_pkg::IN_W-1:0]   vec_s1;
	logic [MAX_LENGTH-1:0]      bad;

	assign busy = s1_valid_q && full;
	assign push = s1_valid_q && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (start && !busy) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			vec_s1 <= symbols;
		end
	end

	for (genvar j = 0; j < MAX_LENGTH; j++) begin : g_slot
		localparam logic [qpm_pkg::POS_W-1:0] JV = qpm_pkg::POS_W'(j);
		localparam logic [qpm_pkg::N_W:0]     JN = (qpm_pkg::N_W + 1)'(j);
		logic [qpm_pkg::SYM_W-1:0] v;
		logic [qpm_pkg::POS_W-1:0] m;

		if (j < qpm_pkg::NUM_SLOTS) begin : g_in
			assign v = vec_s1[qpm_pkg::SYM_W*j +: qpm_pkg::SYM_W];
		end else begin : g_zero
			assign v = '0;
		end

		assign m = qpm_pkg::POS_W'({2'd0, cfg.q_eff}) + JV * qpm_pkg::POS_W'({4'd0, cfg.qb});
		assign bad[j] = (JN < {1'b0, cfg.n_eff}) && ({1'b0, v} >= cfg.q_eff);
		assign push_vr[j] = qpm_pkg::sym_mod(v, m);
	end

	assign push_err = |bad;

endmodule

/* hw/rtl/qpm_back.sv */
module qpm_back #(
	parameter int MAX_LENGTH = 8
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  qpm_pkg::cfg_t                             cfg,
	input  logic                                      rd_valid,
	input  logic                                      rd_err,
	input  logic [MAX_LENGTH-1:0][qpm_pkg::SYM_W-1:0] rd_vr,
	output logic                                      pop,
	output logic                                      strobe,
	output logic [qpm_pkg::OUT_W-1:0]                 perm_symbol,
	output logic [qpm_pkg::OUT_W-1:0]                 position,
	output logic                                      last,
	output logic                                      symbol_error
);

	localparam int PW = qpm_pkg::POS_W;
	localparam int SW = qpm_pkg::SUM_W;

	logic                                      act_q;
	logic [PW-1:0]                             pos_q;
	logic                                      err_q;
	logic [MAX_LENGTH-1:0][qpm_pkg::SYM_W-1:0] vr_q;
	logic                                      last_issue;

	logic                                      valid_s [MAX_LENGTH];
	logic [PW-1:0]                             p_s     [MAX_LENGTH];
	logic [PW-1:0]                             i_s     [MAX_LENGTH];
	logic                                      last_s  [MAX_LENGTH];
	logic                                      err_s   [MAX_LENGTH];
	logic [MAX_LENGTH-1:0][qpm_pkg::SYM_W-1:0] vr_s    [MAX_LENGTH];

	assign last_issue = act_q && (pos_q == cfg.total - PW'(1));
	assign pop        = (!act_q || last_issue) && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			pos_q <= '0;
		end else if (pop) begin
			act_q <= 1'b1;
			pos_q <= '0;
		end else if (last_issue) begin
			act_q <= 1'b0;
		end else if (act_q) begin
			pos_q <= pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			vr_q  <= rd_vr;
			err_q <= rd_err;
		end
	end

	for (genvar k = 0; k < MAX_LENGTH; k++) begin : g_stage
		localparam logic [PW-1:0]            KV = PW'(k);
		localparam logic [qpm_pkg::N_W:0]    KN = (qpm_pkg::N_W + 1)'(k);
		logic                                      v_in;
		logic [PW-1:0]                             p_in;
		logic [PW-1:0]                             i_in;
		logic                                      l_in;
		logic                                      e_in;
		logic [MAX_LENGTH-1:0][qpm_pkg::SYM_W-1:0] vr_in;
		logic [PW-1:0]                             m;
		logic [SW-1:0]                             s;
		logic [SW-1:0]                             s_red;
		logic                                      apply;

		if (k == 0) begin : g_head
			assign v_in  = act_q;
			assign p_in  = pos_q;
			assign i_in  = pos_q;
			assign l_in  = last_issue;
			assign e_in  = err_q;
			assign vr_in = vr_q;
		end else begin : g_link
			assign v_in  = valid_s[k-1];
			assign p_in  = p_s[k-1];
			assign i_in  = i_s[k-1];
			assign l_in  = last_s[k-1];
			assign e_in  = err_s[k-1];
			assign vr_in = vr_s[k-1];
		end

		assign m     = PW'({2'd0, cfg.q_eff}) + KV * PW'({4'd0, cfg.qb});
		assign apply = (KN < {1'b0, cfg.n_eff}) && (m > i_in);
		assign s     = {1'b0, p_in} + SW'(vr_in[k]);
		assign s_red = (s >= {1'b0, m}) ? s - {1'b0, m} : s;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			p_s[k]    <= apply ? s_red[PW-1:0] : p_in;
			i_s[k]    <= i_in;
			last_s[k] <= l_in;
			err_s[k]  <= e_in;
			vr_s[k]   <= vr_in;
		end
	end

	assign strobe       = valid_s[MAX_LENGTH-1];
	assign perm_symbol  = p_s[MAX_LENGTH-1][qpm_pkg::OUT_W-1:0];
	assign position     = i_s[MAX_LENGTH-1][qpm_pkg::OUT_W-1:0];
	assign last         = last_s[MAX_LENGTH-1];
	assign symbol_error = err_s[MAX_LENGTH-1];

endmodule

/* bench/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LENGTH   = 8;
	localparam int MAX_ALPHABET = 16;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 3 * (MAX_LENGTH + 3);

	localparam logic [qpm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [qpm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [qpm_pkg::OUT_W-1:0] perm_symbol;
		logic [qpm_pkg::OUT_W-1:0] position;
		logic                      last;
		logic                      symbol_error;
	} entry_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [qpm_pkg::IN_W-1:0]       symbols;
	logic                           strobe;
	logic [qpm_pkg::OUT_W-1:0]      perm_symbol;
	logic [qpm_pkg::OUT_W-1:0]      position;
	logic                           last;
	logic                           symbol_error;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [qpm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [qpm_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [qpm_pkg::Q_W-1:0] alphabet_reg;
	logic [qpm_pkg::N_W-1:0] length_reg;
	entry_t                  expected_entries[$];
	int                      mismatch_count = 0;
	int                      quiet_cycles = 0;
	int                      sender_idle_pct = 0;

	qary_to_permutation_mapper #(
		.MAX_LENGTH  (MAX_LENGTH),
		.MAX_ALPHABET(MAX_ALPHABET)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.symbols     (symbols),
		.strobe      (strobe),
		.perm_symbol (perm_symbol),
		.position    (position),
		.last        (last),
		.symbol_error(symbol_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_alphabet(logic [qpm_pkg::Q_W-1:0] raw);
		int unsigned q;
		q = raw;
		if (q < 2) begin
			q = 2;
		end
		if (q > MAX_ALPHABET) begin
			q = MAX_ALPHABET;
		end
		return q;
	endfunction

	function automatic int unsigned clamp_length(logic [qpm_pkg::N_W-1:0] raw);
		int unsigned n;
		n = raw;
		if (n < 1) begin
			n = 1;
		end
		if (n > MAX_LENGTH) begin
			n = MAX_LENGTH;
		end
		return n;
	endfunction

	function automatic void predict_permutation(logic [qpm_pkg::IN_W-1:0] vec);
		int unsigned q, n, qb, total, skip, p, s, m;
		logic        err;
		entry_t      e;
		q = clamp_alphabet(alphabet_reg);
		n = clamp_length(length_reg);
		qb = 0;
		while ((1 << qb) < q) begin
			qb++;
		end
		total = q + (n - 1) * qb;
		err = 1'b0;
		for (int j = 0; j < n; j++) begin
			if (vec[qpm_pkg::SYM_W*j +: qpm_pkg::SYM_W] >= q) begin
				err = 1'b1;
			end
		end
		skip = 0;
		for (int unsigned i = 0; i < total; i++) begin
			p = i;
			while (skip < n && q + skip * qb <= i) begin
				skip++;
			end
			for (int unsigned j = skip; j < n; j++) begin
				m = q + j * qb;
				s = p + vec[qpm_pkg::SYM_W*j +: qpm_pkg::SYM_W];
				if (s >= m) begin
					s -= m;
				end
				if (s >= m) begin
					s %= m;
				end
				p = s;
			end
			e.perm_symbol  = p[qpm_pkg::OUT_W-1:0];
			e.position     = i[qpm_pkg::OUT_W-1:0];
			e.last         = (i + 1 == total);
			e.symbol_error = err;
			expected_entries.push_back(e);
		end
	endfunction

	task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
		if (exp_val != act_val) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
		end
	endtask

	always @(posedge clk) begin
		entry_t e;
		if (arst_n && strobe) begin
			if (expected_entries.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual position %0d",
					$time, position);
			end else begin
				e = expected_entries.pop_front();
				compare_field("perm_symbol", e.perm_symbol, perm_symbol);
				compare_field("position", e.position, position);
				compare_field("last", e.last, last);
				compare_field("symbol_error", e.symbol_error, symbol_error);
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// start stays high on return so back-to-back items need no drop
	task automatic send_vector(logic [qpm_pkg::IN_W-1:0] vec);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start   = 1'b1;
		symbols = vec;
		do begin
			@(posedge clk);
		end while (busy);
		predict_permutation(vec);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (expected_entries.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(logic [qpm_pkg::CFG_IDX_W-1:0] idx,
			logic [qpm_pkg::CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		if (idx == qpm_pkg::REG_ALPHABET) begin
			alphabet_reg = data;
		end else if (idx == qpm_pkg::REG_LENGTH) begin
			length_reg = data[qpm_pkg::N_W-1:0];
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_reset_config();
		send_vector(32'h0000_0000);
		send_vector(32'h0000_0111);
		send_vector(32'hFFFF_FFFF);
		send_vector(32'h0000_0010);
	endtask

	task automatic test_widest_config();
		write_reg(qpm_pkg::REG_ALPHABET, 5'd16);
		write_reg(qpm_pkg::REG_LENGTH, 5'd8);
		send_vector(32'h0000_0000);
		send_vector(32'hFFFF_FFFF);
		send_vector(32'h0F0F_0F0F);
		send_vector(32'h1234_5678);
	endtask

	task automatic test_out_of_range_config();
		write_reg(qpm_pkg::REG_ALPHABET, 5'd31);
		write_reg(qpm_pkg::REG_LENGTH, 5'd15);
		send_vector(32'hFEDC_BA98);
		write_reg(qpm_pkg::REG_ALPHABET, 5'd0);
		write_reg(qpm_pkg::REG_LENGTH, 5'd0);
		send_vector(32'h0000_0001);
		send_vector(32'h0000_0002);
		write_reg(qpm_pkg::REG_ALPHABET, 5'd1);
		write_reg(qpm_pkg::REG_LENGTH, 5'd17);
		send_vector(32'hFFFF_FFF1);
		write_reg(qpm_pkg::REG_ALPHABET, 5'd17);
		write_reg(qpm_pkg::REG_LENGTH, 5'd9);
		send_vector(32'h89AB_CDEF);
	endtask

	task automatic test_invalid_symbols();
		write_reg(qpm_pkg::REG_ALPHABET, 5'd5);
		write_reg(qpm_pkg::REG_LENGTH, 5'd8);
		send_vector(32'h4444_4444);
		send_vector(32'h0000_0005);
		send_vector(32'h5000_0000);
		send_vector(32'hF0F0_F0F0);
		write_reg(qpm_pkg::REG_LENGTH, 5'd1);
		send_vector(32'hFFFF_FFF4);
		send_vector(32'h0000_0009);
		write_reg(qpm_pkg::REG_ALPHABET, 5'd9);
		write_reg(qpm_pkg::REG_LENGTH, 5'd4);
		send_vector(32'hFFFF_8888);
		send_vector(32'h0000_9000);
	endtask

	task automatic test_spare_index();
		write_reg(REG_SPARE_A, 5'(($urandom)));
		write_reg(REG_SPARE_B, 5'd31);
		send_vector(32'h0000_3021);
	endtask

	task automatic test_random_phase(int idle_pct, int count);
		int unsigned              q;
		logic [qpm_pkg::IN_W-1:0] vec;
		sender_idle_pct = idle_pct;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0) begin
				if ($urandom_range(3) == 0) begin
					write_reg(qpm_pkg::REG_ALPHABET, 5'($urandom_range(31)));
				end else begin
					write_reg(qpm_pkg::REG_ALPHABET, 5'($urandom_range(MAX_ALPHABET, 2)));
				end
				if ($urandom_range(3) == 0) begin
					write_reg(qpm_pkg::REG_LENGTH, 5'($urandom_range(31)));
				end else begin
					write_reg(qpm_pkg::REG_LENGTH, 5'($urandom_range(MAX_LENGTH, 1)));
				end
			end
			if ($urandom_range(4) == 0) begin
				vec = $urandom;
			end else begin
				q = clamp_alphabet(alphabet_reg);
				for (int j = 0; j < qpm_pkg::NUM_SLOTS; j++) begin
					vec[qpm_pkg::SYM_W*j +: qpm_pkg::SYM_W] =
						qpm_pkg::SYM_W'($urandom_range(q - 1));
				end
			end
			send_vector(vec);
		end
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		symbols      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = qpm_pkg::REG_ALPHABET;
		cfg_data     = '0;
		alphabet_reg = qpm_pkg::ALPHABET_RST;
		length_reg   = qpm_pkg::LENGTH_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_config();
		test_widest_config();
		test_out_of_range_config();
		test_invalid_symbols();
		test_spare_index();
		write_reg(qpm_pkg::REG_ALPHABET, 5'd4);
		write_reg(qpm_pkg::REG_LENGTH, 5'd3);
		test_random_phase(6, 33);
		test_random_phase(62, 33);
		test_random_phase(0, 33);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/qpm_pkg.sv
hw/rtl/qpm_fifo.sv
hw/rtl/qpm_front.sv
hw/rtl/qpm_back.sv
hw/rtl/qary_to_permutation_mapper.sv
bench/testbench.sv
